/* rtl/dstq_pkg.sv */
// Shared constants, codes and types for the deadline-sorted timer queue.
package dstq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TAG_W       = 8;
    localparam int DELAY_W     = 32;
    localparam int TIME_W      = 64;
    localparam int ENTRY_W     = TIME_W + TAG_W;

    localparam logic       CMD_TICK = 1'b0;
    localparam logic       CMD_ADD  = 1'b1;

    localparam logic [1:0] KIND_EXPIRED = 2'd0;
    localparam logic [1:0] KIND_ADDED   = 2'd1;
    localparam logic [1:0] KIND_FULL    = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    typedef struct packed {
        logic [TIME_W-1:0] op_a;
        logic [TIME_W-1:0] op_b;
    } alu_req_t;

    typedef struct packed {
        logic [TIME_W-1:0] sum;
        logic              le;
    } alu_rsp_t;

endpackage

/* rtl/dstq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module dstq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/dstq_alu.sv */
// Shared 64-bit adder and unsigned less-or-equal comparator.
module dstq_alu
    import dstq_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    always_comb
    begin
        rsp.sum = req.op_a + req.op_b;
        rsp.le  = (req.op_a <= req.op_b);
    end

endmodule

/* rtl/deadline_sorted_timer_queue_top.sv */
// Top level of the deadline-sorted timer queue: sequencer, table RAM and shared unit.
//
//  Channel  | Handshake          | Signals
//  ---------+--------------------+----------------------------------------------
//  command  | start, busy        | command, timer_tag, timeout
//  result   | result_valid       | kind, expired_tag, deadline, last
//
// An add sums its deadline, shifts up the entries not earlier than it, and writes it in the gap.
// A rejected add never raises busy; its result is strobed in the cycle after acceptance.
// A tick advances the tick counter, ending there on an empty table, then compares entries from
// the head until one survives, ends if none expired, else emits those and moves the rest down.
// Reset clears the count, the tick counter, the result strobe and the sequencer; the table needs no clearing.
// Results are strobed one cycle each, the cycle after their state, and cannot be stalled.
module deadline_sorted_timer_queue_top
    import dstq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               command,
    input  logic [TAG_W-1:0]   timer_tag,
    input  logic [DELAY_W-1:0] timeout,
    output logic               result_valid,
    output logic [1:0]         kind,
    output logic [TAG_W-1:0]   expired_tag,
    output logic [TIME_W-1:0]  deadline,
    output logic               last
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_ADD_SUM   = 3'd1;
    localparam logic [2:0] S_ADD_CMP   = 3'd2;
    localparam logic [2:0] S_ADD_PUT   = 3'd3;
    localparam logic [2:0] S_TICK_INC  = 3'd4;
    localparam logic [2:0] S_TICK_CMP  = 3'd5;
    localparam logic [2:0] S_TICK_EMIT = 3'd6;
    localparam logic [2:0] S_TICK_MOVE = 3'd7;

    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

    logic [2:0]         state_reg, state_next;
    logic [TIME_W-1:0]  tick_count_reg, tick_count_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [TIME_W-1:0]  dl_reg, dl_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;

    logic               valid_reg, valid_next;
    logic [1:0]         kind_reg, kind_next;
    logic [TAG_W-1:0]   otag_reg, otag_next;
    logic [TIME_W-1:0]  odl_reg, odl_next;
    logic               last_reg, last_next;

    logic               wr_en;
    logic [CNT_W-1:0]   wr_idx;
    entry_t             wr_entry;
    logic [ENTRY_W-1:0] rd_data;
    entry_t             rd_entry;
    alu_req_t           alu_req;
    alu_rsp_t           alu_rsp;

    assign rd_entry = entry_t'(rd_data);

    dstq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx[ADDR_W-1:0]),
        .wr_data (wr_entry),
        .rd_addr (idx_next[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    dstq_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    always_comb
    begin
        state_next      = state_reg;
        tick_count_next = tick_count_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        dl_next         = dl_reg;
        tag_next        = tag_reg;
        delay_next      = delay_reg;
        valid_next      = 1'b0;
        kind_next       = kind_reg;
        otag_next       = otag_reg;
        odl_next        = odl_reg;
        last_next       = last_reg;
        wr_en           = 1'b0;
        wr_idx          = idx_reg;
        wr_entry        = rd_entry;
        alu_req.op_a    = tick_count_reg;
        alu_req.op_b    = {{(TIME_W-DELAY_W){1'b0}}, delay_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    tag_next   = timer_tag;
                    delay_next = timeout;
                    if (command == CMD_ADD)
                    begin
                        if (count_reg == FULL)
                        begin
                            valid_next = 1'b1;
                            kind_next  = KIND_FULL;
                            otag_next  = '0;
                            odl_next   = '0;
                            last_next  = 1'b1;
                        end
                        else
                        begin
                            state_next = S_ADD_SUM;
                        end
                    end
                    else
                    begin
                        state_next = S_TICK_INC;
                    end
                end
            end

            S_ADD_SUM:
            begin
                dl_next = alu_rsp.sum;
                if (count_reg == '0)
                begin
                    idx_next   = '0;
                    state_next = S_ADD_PUT;
                end
                else
                begin
                    idx_next   = count_reg - ONE;
                    state_next = S_ADD_CMP;
                end
            end

            S_ADD_CMP:
            begin
                alu_req.op_a = dl_reg;
                alu_req.op_b = rd_entry.deadline;
                if (alu_rsp.le)
                begin
                    wr_en  = 1'b1;
                    wr_idx = idx_reg + ONE;
                    if (idx_reg == '0)
                    begin
                        state_next = S_ADD_PUT;
                    end
                    else
                    begin
                        idx_next = idx_reg - ONE;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + ONE;
                    state_next = S_ADD_PUT;
                end
            end

            S_ADD_PUT:
            begin
                wr_en             = 1'b1;
                wr_entry.deadline = dl_reg;
                wr_entry.tag      = tag_reg;
                count_next        = count_reg + ONE;
                valid_next        = 1'b1;
                kind_next         = KIND_ADDED;
                otag_next         = tag_reg;
                odl_next          = dl_reg;
                last_next         = 1'b1;
                state_next        = S_IDLE;
            end

            S_TICK_INC:
            begin
                alu_req.op_b    = TIME_W'(1);
                tick_count_next = alu_rsp.sum;
                n_next          = '0;
                if (count_reg == '0)
                begin
                    valid_next = 1'b1;
                    kind_next  = KIND_NONE;
                    otag_next  = '0;
                    odl_next   = '0;
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_TICK_CMP;
                end
            end

            S_TICK_CMP:
            begin
                alu_req.op_a = rd_entry.deadline;
                alu_req.op_b = tick_count_reg;
                if (alu_rsp.le)
                begin
                    n_next = idx_reg + ONE;
                    if (idx_reg + ONE == count_reg)
                    begin
                        idx_next   = '0;
                        state_next = S_TICK_EMIT;
                    end
                    else
                    begin
                        idx_next = idx_reg + ONE;
                    end
                end
                else if (n_reg == '0)
                begin
                    valid_next = 1'b1;
                    kind_next  = KIND_NONE;
                    otag_next  = '0;
                    odl_next   = '0;
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_TICK_EMIT;
                end
            end

            S_TICK_EMIT:
            begin
                valid_next = 1'b1;
                kind_next  = KIND_EXPIRED;
                otag_next  = rd_entry.tag;
                odl_next   = rd_entry.deadline;
                last_next  = (idx_reg + ONE == n_reg);
                if (idx_reg + ONE == n_reg)
                begin
                    if (n_reg == count_reg)
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = n_reg;
                        state_next = S_TICK_MOVE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + ONE;
                end
            end

            S_TICK_MOVE:
            begin
                wr_en  = 1'b1;
                wr_idx = idx_reg - n_reg;
                if (idx_reg + ONE == count_reg)
                begin
                    count_next = count_reg - n_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + ONE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tick_count_reg <= '0;
            count_reg      <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_count_reg <= tick_count_next;
            count_reg      <= count_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        n_reg     <= n_next;
        dl_reg    <= dl_next;
        tag_reg   <= tag_next;
        delay_reg <= delay_next;
        kind_reg  <= kind_next;
        otag_reg  <= otag_next;
        odl_reg   <= odl_next;
        last_reg  <= last_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = valid_reg;
    assign kind         = kind_reg;
    assign expired_tag  = otag_reg;
    assign deadline     = odl_reg;
    assign last         = last_reg;

endmodule

/* rtl/dstq_checker.sv */
// Port-level checker for the timer queue, bound to the top level.
module dstq_checker
    import dstq_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               result_valid,
    input logic [1:0]         kind,
    input logic [TAG_W-1:0]   expired_tag,
    input logic [TIME_W-1:0]  deadline,
    input logic               last
);

    // An accepted item either occupies the block or is answered at once.
    a_accept_answered: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || result_valid))
        else $error("accepted item neither made the block busy nor produced a result");

    // A run of expired items is emitted back to back until the one marked last.
    a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |=> result_valid)
        else $error("gap inside a burst of expired items");

    // While further items of the same burst are due, no new command may be taken.
    a_busy_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> busy)
        else $error("block idle with results still outstanding");

    // Single-result answers carry last and empty payload fields.
    a_empty_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (kind == KIND_FULL || kind == KIND_NONE))
            |-> (last && expired_tag == '0 && deadline == '0))
        else $error("rejected add or empty tick carries payload or misses last");

endmodule

bind deadline_sorted_timer_queue_top dstq_checker u_dstq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .kind         (kind),
    .expired_tag  (expired_tag),
    .deadline     (deadline),
    .last         (last)
);
